@@ rtl/differential_drive_odometry_core_assert.svh @@
// Assertion macros for the odometry core.
// Included by the top level only; no other dependencies.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry core: next-cycle check failed");

`endif

@@ rtl/ddo_pkg.sv @@
// Shared constants, types and the arctangent table of the odometry core.
// No dependencies; every RTL file but the assertion header refers to it by scoped names.
package ddo_pkg;

	// parameter defaults
	localparam int TICK_BITS_DEF = 16;
	localparam int TRIG_ITER_DEF = 16;
	localparam int ATAN_STEPS    = 24;
	localparam int IT_W          = 5;

	// field and datapath widths
	localparam int DIST_W     = 32;
	localparam int ANG_W      = 32;
	localparam int POS_W      = 48;
	localparam int POS_OUT_W  = 32;
	localparam int HEAD_OUT_W = 16;
	localparam int TURN_W     = 33;
	localparam int C_W        = 33;
	localparam int Z_W        = 33;
	localparam int UT_W       = 32;
	localparam int FRAC_SH    = 31;
	localparam int ACC_W      = POS_W + FRAC_SH;
	localparam int MUL1_STEPS = (TURN_W + 1) / 2;
	localparam int MUL2_STEPS = UT_W / 2;
	localparam int CNT_W      = 5;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 3'd4;

	// register reset values
	localparam logic [DIST_W-1:0]     DIST_RST = 32'd3748053;
	localparam logic [ANG_W-1:0]      TURN_RST = 32'd2840555;
	localparam logic [POS_OUT_W-1:0]  X_RST    = 32'd65536;
	localparam logic [POS_OUT_W-1:0]  Y_RST    = 32'd203162;
	localparam logic [HEAD_OUT_W-1:0] HEAD_RST = 16'd16384;

	// CORDIC constants
	localparam logic signed [C_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
	localparam logic [ANG_W-1:0]      OCTANT      = 32'h2000_0000;

	typedef struct packed {
		logic load;
		logic step;
	} ddo_mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ddo_cord_sts_t;

	// arctan(2^-i) in units of 2^-32 revolution
	function automatic logic [ANG_W-1:0] atan_lut(input logic [IT_W-1:0] i);
		logic [ANG_W-1:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/ddo_if.sv @@
// Valid/ready channel interfaces of the odometry core: ticks in, pose out,
// register writes. Depends on ddo_pkg for widths.
interface ddo_in_if #(
	parameter int TICK_BITS = ddo_pkg::TICK_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [TICK_BITS-1:0] left_ticks;
	logic signed [TICK_BITS-1:0] right_ticks;

	modport source (output valid, output left_ticks, output right_ticks, input ready);
	modport sink (input valid, input left_ticks, input right_ticks, output ready);
endinterface

interface ddo_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ddo_pkg::POS_OUT_W-1:0]   x_out;
	logic signed [ddo_pkg::POS_OUT_W-1:0]   y_out;
	logic        [ddo_pkg::HEAD_OUT_W-1:0]  heading_out;

	modport source (output valid, output x_out, output y_out, output heading_out,
		input ready);
	modport sink (input valid, input x_out, input y_out, input heading_out,
		output ready);
endinterface

interface ddo_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ddo_pkg::CFG_IDX_W-1:0]   index;
	logic [ddo_pkg::DIST_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ddo_serial_mul.sv @@
// Radix-4 shift-and-add multiplier: one two-bit digit of the multiplier per step.
// Depends on ddo_pkg for the control struct.
module ddo_serial_mul #(
	parameter int MC_W = 32,
	parameter int MP_W = 32,
	parameter int AC_W = 64
) (
	input  logic                  clk,
	input  ddo_pkg::ddo_mul_ctl_t ctl,
	input  logic [MC_W-1:0]       mcand,
	input  logic [MP_W-1:0]       mplier,
	output logic [AC_W-1:0]       prod
);

	logic [AC_W-1:0] mc_q;
	logic [AC_W-1:0] acc_q;
	logic [MP_W-1:0] mp_q;
	logic [AC_W-1:0] pp0;
	logic [AC_W-1:0] pp1;

	assign pp0  = mp_q[0] ? mc_q : '0;
	assign pp1  = mp_q[1] ? {mc_q[AC_W-2:0], 1'b0} : '0;
	assign prod = acc_q;

	// product bits above AC_W are dropped: the result is taken modulo 2^AC_W
	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			mc_q  <= AC_W'(mcand);
			mp_q  <= mplier;
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= acc_q + pp0 + pp1;
			mc_q  <= {mc_q[AC_W-3:0], 2'b00};
			mp_q  <= {2'b00, mp_q[MP_W-1:2]};
		end else begin
			// hold
		end
	end

endmodule

@@ rtl/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving cos and
// sin of a 32-bit binary angle in Q2.30. Depends on ddo_pkg.
module ddo_cordic #(
	parameter int ITER = ddo_pkg::TRIG_ITER_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ddo_pkg::ANG_W-1:0]         angle,
	output ddo_pkg::ddo_cord_sts_t            sts,
	output logic signed [ddo_pkg::C_W-1:0]    co,
	output logic signed [ddo_pkg::C_W-1:0]    si
);

	logic signed [ddo_pkg::C_W-1:0] x_q;
	logic signed [ddo_pkg::C_W-1:0] y_q;
	logic signed [ddo_pkg::Z_W-1:0] z_q;
	logic [1:0]                     q_q;
	logic [ddo_pkg::IT_W-1:0]       it_q;
	logic                           busy_q;
	logic                           done_q;

	logic [ddo_pkg::ANG_W-1:0]        qa_c;
	logic [1:0]                       q_c;
	logic [ddo_pkg::ANG_W-1:0]        u_c;
	logic signed [ddo_pkg::ANG_W-1:0] us_c;
	logic signed [ddo_pkg::Z_W-1:0]   z0_c;
	logic signed [ddo_pkg::C_W-1:0]   sx_c;
	logic signed [ddo_pkg::C_W-1:0]   sy_c;
	logic signed [ddo_pkg::Z_W-1:0]   atan_c;

	// split off the nearest quarter turn, leaving a residual of at most 1/8 turn
	assign qa_c   = angle + ddo_pkg::OCTANT;
	assign q_c    = qa_c[ddo_pkg::ANG_W-1 -: 2];
	assign u_c    = angle - {q_c, {(ddo_pkg::ANG_W-2){1'b0}}};
	assign us_c   = signed'(u_c);
	assign z0_c   = ddo_pkg::Z_W'(us_c);
	assign sx_c   = x_q >>> it_q;
	assign sy_c   = y_q >>> it_q;
	assign atan_c = ddo_pkg::Z_W'(ddo_pkg::atan_lut(it_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + ddo_pkg::IT_W'(1);
				if (it_q == ddo_pkg::IT_W'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= ddo_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= z0_c;
			q_q <= q_c;
		end else if (busy_q) begin
			if (!z_q[ddo_pkg::Z_W-1]) begin
				x_q <= x_q - sy_c;
				y_q <= y_q + sx_c;
				z_q <= z_q - atan_c;
			end else begin
				x_q <= x_q + sy_c;
				y_q <= y_q - sx_c;
				z_q <= z_q + atan_c;
			end
		end
	end

	// restore the quarter turn by exact sign change and swap
	always_comb begin
		unique case (q_q)
			2'd0: begin co = x_q;  si = y_q;  end
			2'd1: begin co = -y_q; si = x_q;  end
			2'd2: begin co = -x_q; si = -y_q; end
			2'd3: begin co = y_q;  si = -x_q; end
			default: begin co = x_q; si = y_q; end
		endcase
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ rtl/differential_drive_odometry_core.sv @@
// Differential-drive dead-reckoning odometry core (top level).
// Depends on ddo_pkg, the channel interfaces, ddo_serial_mul, ddo_cordic
// and the assertion macro header.
//
// Usage:
//  - ticks: one transaction carries the signed left and right encoder deltas.
//  - pose:  one transaction per tick transaction, the updated x, y (Q16.16)
//           and the top 16 bits of the heading angle.
//  - cfg:   register writes, always ready. Index 0 travel per tick, 1 turn per
//           tick, 2..4 the initial pose; a write to 2..4 reloads the pose.
//           Write only while no tick transaction is in flight.
//  - Sequence: the radix-4 multipliers take the turn and travel products in 17
//    digit steps, the single shared CORDIC stage runs N micro-rotations with
//    N = min(TRIG_ITERATIONS, 24), and the displacements take 16 digit steps,
//    one step per cycle, before the pose update. The next tick transaction
//    is taken only once the previous one has passed its pose update.
//  - Reset: registers take their reset values and the pose loads from them.
//  - Stall: while the pose waits on a stalled receiver, the next tick
//    transaction is still taken and computed; only the final pose update
//    holds until the waiting pose is taken, so no result is lost.
`include "differential_drive_odometry_core_assert.svh"

module differential_drive_odometry_core #(
	parameter int TICK_BITS       = ddo_pkg::TICK_BITS_DEF,
	parameter int TRIG_ITERATIONS = ddo_pkg::TRIG_ITER_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ddo_in_if.sink       ticks,
	ddo_out_if.source    pose,
	ddo_cfg_if.sink      cfg
);

	localparam int SUM_W  = TICK_BITS + 1;
	localparam int DS_W   = ddo_pkg::DIST_W + SUM_W;
	localparam int CORD_N = (TRIG_ITERATIONS < ddo_pkg::ATAN_STEPS) ?
		TRIG_ITERATIONS : ddo_pkg::ATAN_STEPS;

	// sequencer codes
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL1   = 3'd1;
	localparam logic [2:0] S_CSTART = 3'd2;
	localparam logic [2:0] S_CORD   = 3'd3;
	localparam logic [2:0] S_MUL2   = 3'd4;
	localparam logic [2:0] S_UPD    = 3'd5;

	logic [2:0]                state_q;
	logic [ddo_pkg::CNT_W-1:0] cnt_q;

	// configuration registers
	logic [ddo_pkg::DIST_W-1:0]     dist_q;
	logic [ddo_pkg::ANG_W-1:0]      turn_q;
	logic [ddo_pkg::POS_OUT_W-1:0]  init_x_q;
	logic [ddo_pkg::POS_OUT_W-1:0]  init_y_q;
	logic [ddo_pkg::HEAD_OUT_W-1:0] init_h_q;

	// pose state
	logic [ddo_pkg::POS_W-1:0] pos_x_q;
	logic [ddo_pkg::POS_W-1:0] pos_y_q;
	logic [ddo_pkg::ANG_W-1:0] heading_q;
	logic                      out_valid_q;

	// per-item signs
	logic sum_neg_q;
	logic neg_x_q;
	logic neg_y_q;

	// input arithmetic
	logic signed [SUM_W-1:0]   l_ext;
	logic signed [SUM_W-1:0]   r_ext;
	logic signed [SUM_W-1:0]   sum_c;
	logic signed [SUM_W-1:0]   diff_c;
	logic [SUM_W-1:0]          usum_c;
	logic [ddo_pkg::TURN_W-1:0] diff_ext;
	logic                      in_acc;
	logic                      cfg_acc;

	// multiplier and CORDIC connections
	ddo_pkg::ddo_mul_ctl_t      mul1_ctl;
	ddo_pkg::ddo_mul_ctl_t      mul2_ctl;
	ddo_pkg::ddo_cord_sts_t     cord_sts;
	logic [ddo_pkg::TURN_W-1:0] turn_prod;
	logic [DS_W-1:0]            ds_prod;
	logic [ddo_pkg::ACC_W-1:0]  px_prod;
	logic [ddo_pkg::ACC_W-1:0]  py_prod;
	logic [ddo_pkg::ANG_W-1:0]  mid_c;
	logic signed [ddo_pkg::C_W-1:0] co;
	logic signed [ddo_pkg::C_W-1:0] si;
	logic [ddo_pkg::C_W-1:0]    aco_c;
	logic [ddo_pkg::C_W-1:0]    asi_c;

	// pose update
	logic [ddo_pkg::POS_W-1:0] resx_c;
	logic [ddo_pkg::POS_W-1:0] resy_c;
	logic [ddo_pkg::POS_W-1:0] dx_c;
	logic [ddo_pkg::POS_W-1:0] dy_c;
	logic                      upd_go;

	// config reload values
	logic [ddo_pkg::POS_OUT_W-1:0]  nx_c;
	logic [ddo_pkg::POS_OUT_W-1:0]  ny_c;
	logic [ddo_pkg::HEAD_OUT_W-1:0] nh_c;
	logic                           reload_c;

	assign ticks.ready = (state_q == S_IDLE);
	assign in_acc      = ticks.valid && ticks.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_acc     = cfg.valid && cfg.ready;

	// sum and difference are exact one bit wider than the ticks
	assign l_ext    = SUM_W'(ticks.left_ticks);
	assign r_ext    = SUM_W'(ticks.right_ticks);
	assign sum_c    = l_ext + r_ext;
	assign diff_c   = r_ext - l_ext;
	assign usum_c   = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
	assign diff_ext = ddo_pkg::TURN_W'(diff_c);

	// turn and dist*|sum| share the first multiply pass
	assign mul1_ctl.load = in_acc;
	assign mul1_ctl.step = (state_q == S_MUL1);
	assign mul2_ctl.load = (state_q == S_CORD) && cord_sts.done;
	assign mul2_ctl.step = (state_q == S_MUL2);

	ddo_serial_mul #(
		.MC_W (ddo_pkg::ANG_W),
		.MP_W (ddo_pkg::TURN_W),
		.AC_W (ddo_pkg::TURN_W)
	) u_mul_turn (
		.clk    (clk),
		.ctl    (mul1_ctl),
		.mcand  (turn_q),
		.mplier (diff_ext),
		.prod   (turn_prod)
	);

	ddo_serial_mul #(
		.MC_W (ddo_pkg::DIST_W),
		.MP_W (SUM_W),
		.AC_W (DS_W)
	) u_mul_dist (
		.clk    (clk),
		.ctl    (mul1_ctl),
		.mcand  (dist_q),
		.mplier (usum_c),
		.prod   (ds_prod)
	);

	// midpoint heading: add half the turn (floor halving, wraps per revolution)
	assign mid_c = heading_q + turn_prod[ddo_pkg::TURN_W-1:1];

	ddo_cordic #(
		.ITER (CORD_N)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_CSTART),
		.angle  (mid_c),
		.sts    (cord_sts),
		.co     (co),
		.si     (si)
	);

	// magnitudes stay below 2^31, so UT_W bits carry them whole
	assign aco_c = co[ddo_pkg::C_W-1] ? ddo_pkg::C_W'(-co) : ddo_pkg::C_W'(co);
	assign asi_c = si[ddo_pkg::C_W-1] ? ddo_pkg::C_W'(-si) : ddo_pkg::C_W'(si);

	ddo_serial_mul #(
		.MC_W (DS_W),
		.MP_W (ddo_pkg::UT_W),
		.AC_W (ddo_pkg::ACC_W)
	) u_mul_x (
		.clk    (clk),
		.ctl    (mul2_ctl),
		.mcand  (ds_prod),
		.mplier (aco_c[ddo_pkg::UT_W-1:0]),
		.prod   (px_prod)
	);

	ddo_serial_mul #(
		.MC_W (DS_W),
		.MP_W (ddo_pkg::UT_W),
		.AC_W (ddo_pkg::ACC_W)
	) u_mul_y (
		.clk    (clk),
		.ctl    (mul2_ctl),
		.mcand  (ds_prod),
		.mplier (asi_c[ddo_pkg::UT_W-1:0]),
		.prod   (py_prod)
	);

	// drop the 31 fraction bits of the magnitude, then apply the sign
	assign resx_c = px_prod[ddo_pkg::ACC_W-1:ddo_pkg::FRAC_SH];
	assign resy_c = py_prod[ddo_pkg::ACC_W-1:ddo_pkg::FRAC_SH];
	assign dx_c   = neg_x_q ? (~resx_c + 1'b1) : resx_c;
	assign dy_c   = neg_y_q ? (~resy_c + 1'b1) : resy_c;
	assign upd_go = (state_q == S_UPD) && (!out_valid_q || pose.ready);

	// register writes: a pose register write reloads the whole pose
	always_comb begin
		nx_c     = init_x_q;
		ny_c     = init_y_q;
		nh_c     = init_h_q;
		reload_c = 1'b0;
		if (cfg_acc) begin
			unique case (cfg.index)
				ddo_pkg::CFG_X: begin
					nx_c     = cfg.data;
					reload_c = 1'b1;
				end
				ddo_pkg::CFG_Y: begin
					ny_c     = cfg.data;
					reload_c = 1'b1;
				end
				ddo_pkg::CFG_HEAD: begin
					nh_c     = cfg.data[ddo_pkg::HEAD_OUT_W-1:0];
					reload_c = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q   <= ddo_pkg::DIST_RST;
			turn_q   <= ddo_pkg::TURN_RST;
			init_x_q <= ddo_pkg::X_RST;
			init_y_q <= ddo_pkg::Y_RST;
			init_h_q <= ddo_pkg::HEAD_RST;
		end else if (cfg_acc) begin
			if (cfg.index == ddo_pkg::CFG_DIST) begin
				dist_q <= cfg.data;
			end
			if (cfg.index == ddo_pkg::CFG_TURN) begin
				turn_q <= cfg.data;
			end
			init_x_q <= nx_c;
			init_y_q <= ny_c;
			init_h_q <= nh_c;
		end
	end

	// pose state: advance on the update step, reload on a pose register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= {ddo_pkg::X_RST, 16'h0000};
			pos_y_q   <= {ddo_pkg::Y_RST, 16'h0000};
			heading_q <= {ddo_pkg::HEAD_RST, 16'h0000};
		end else begin
			priority if (upd_go) begin
				pos_x_q   <= pos_x_q + dx_c;
				pos_y_q   <= pos_y_q + dy_c;
				heading_q <= heading_q + turn_prod[ddo_pkg::ANG_W-1:0];
			end else if (reload_c) begin
				pos_x_q   <= {nx_c, 16'h0000};
				pos_y_q   <= {ny_c, 16'h0000};
				heading_q <= {nh_c, 16'h0000};
			end else begin
				// hold
			end
		end
	end

	// sign bookkeeping for the two displacements
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_neg_q <= sum_c[SUM_W-1];
		end
		if (mul2_ctl.load) begin
			neg_x_q <= sum_neg_q ^ co[ddo_pkg::C_W-1];
			neg_y_q <= sum_neg_q ^ si[ddo_pkg::C_W-1];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_MUL1;
						cnt_q   <= '0;
					end
				end
				S_MUL1: begin
					cnt_q <= cnt_q + ddo_pkg::CNT_W'(1);
					if (cnt_q == ddo_pkg::CNT_W'(ddo_pkg::MUL1_STEPS - 1)) begin
						state_q <= S_CSTART;
					end
				end
				S_CSTART: begin
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (cord_sts.done) begin
						state_q <= S_MUL2;
						cnt_q   <= '0;
					end
				end
				S_MUL2: begin
					cnt_q <= cnt_q + ddo_pkg::CNT_W'(1);
					if (cnt_q == ddo_pkg::CNT_W'(ddo_pkg::MUL2_STEPS - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output slot: the pose registers themselves hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end else begin
				// hold
			end
		end
	end

	assign pose.valid       = out_valid_q;
	assign pose.x_out       = signed'(pos_x_q[ddo_pkg::POS_W-1 -: ddo_pkg::POS_OUT_W]);
	assign pose.y_out       = signed'(pos_y_q[ddo_pkg::POS_W-1 -: ddo_pkg::POS_OUT_W]);
	assign pose.heading_out = heading_q[ddo_pkg::ANG_W-1 -: ddo_pkg::HEAD_OUT_W];

	// checks
	`DDO_ASSERT_NEXT(a_accept_starts_mul, clk, arst_n, in_acc, state_q == S_MUL1)
	`DDO_ASSERT_NOW(a_cordic_done_in_cord, clk, arst_n, cord_sts.done, state_q == S_CORD)
	`DDO_ASSERT_NEXT(a_stall_holds_pose, clk, arst_n,
		(state_q == S_UPD) && out_valid_q && !pose.ready,
		$stable(pos_x_q) && $stable(pos_y_q) && $stable(heading_q))
	`DDO_ASSERT_NEXT(a_bad_index_no_reload, clk, arst_n,
		(state_q == S_IDLE) && cfg_acc && (cfg.index > ddo_pkg::CFG_HEAD),
		$stable(pos_x_q) && $stable(heading_q))

endmodule

@@ test/tb_differential_drive_odometry_core.sv @@
// Self-checking testbench of the differential-drive odometry core.
// Depends on ddo_pkg, the channel interfaces of ddo_if.sv and the core itself.
// Checks every pose against a bit-exact pose predictor kept inside this module.
module tb_differential_drive_odometry_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICK_W       = ddo_pkg::TICK_BITS_DEF;
	localparam int ROT_ITERS    = ddo_pkg::TRIG_ITER_DEF;
	localparam int ATAN_N       = 24;
	localparam int ROT_STEPS    = (ROT_ITERS < ATAN_N) ? ROT_ITERS : ATAN_N;
	// tick transaction to pose, and on to taking the next one
	localparam int LATENCY      = ROT_STEPS + 37;
	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 5;
	localparam int TOTAL_ITEMS  = 900;
	localparam int CALM_ITEMS   = 100;
	localparam int TIMEOUT_NS   = 4_000_000;
	localparam int TICK_MAX     = (1 << (TICK_W - 1)) - 1;
	localparam int TICK_MIN     = -(1 << (TICK_W - 1));
	localparam int CFG_IDX_LAST = (1 << ddo_pkg::CFG_IDX_W) - 1;
	// first register index the core does not decode
	localparam logic [ddo_pkg::CFG_IDX_W-1:0] CFG_SPARE = ddo_pkg::CFG_HEAD + 3'd1;

	// converged CORDIC gain, Q2.30
	localparam longint ROT_GAIN = 64'sh26DD3B6A;
	// arctan(2^-i) in 2^-32 revolution, entry 0 in the top word
	localparam logic [32*ATAN_N-1:0] ATAN_REV = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [ddo_pkg::POS_OUT_W-1:0]  x;
		logic signed [ddo_pkg::POS_OUT_W-1:0]  y;
		logic        [ddo_pkg::HEAD_OUT_W-1:0] heading;
	} pose_t;

	typedef enum logic [1:0] {JOB_TICKS, JOB_WRITE, JOB_PAUSE} job_kind_t;

	typedef struct {
		job_kind_t                     kind;
		logic signed [TICK_W-1:0]      left_ticks;
		logic signed [TICK_W-1:0]      right_ticks;
		logic [ddo_pkg::CFG_IDX_W-1:0] index;
		logic [ddo_pkg::DIST_W-1:0]    data;
		int unsigned                   hold;      // idle cycles before the transaction
		int unsigned                   stall_pct; // receiver stall odds while it runs
		logic                          calm;      // no idling from here on
	} job_t;

	// Clock, reset and the stimulus-side copies of every core input.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          tick_vld = 1'b0;
	logic signed [TICK_W-1:0]      tick_l   = '0;
	logic signed [TICK_W-1:0]      tick_r   = '0;
	logic                          wr_vld   = 1'b0;
	logic [ddo_pkg::CFG_IDX_W-1:0] wr_idx   = '0;
	logic [ddo_pkg::DIST_W-1:0]    wr_data  = '0;
	logic                          pose_rdy = 1'b0;

	ddo_in_if #(.TICK_BITS(TICK_W)) ticks_ch ();
	ddo_out_if                      pose_ch ();
	ddo_cfg_if                      cfg_ch ();

	// Drive the channels from known values from time zero on.
	assign ticks_ch.valid       = tick_vld;
	assign ticks_ch.left_ticks  = tick_l;
	assign ticks_ch.right_ticks = tick_r;
	assign pose_ch.ready        = pose_rdy;
	assign cfg_ch.valid         = wr_vld;
	assign cfg_ch.index         = wr_idx;
	assign cfg_ch.data          = wr_data;

	differential_drive_odometry_core #(
		.TICK_BITS      (TICK_W),
		.TRIG_ITERATIONS(ROT_ITERS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.ticks (ticks_ch),
		.pose  (pose_ch),
		.cfg   (cfg_ch)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// Pose predictor state: register copies and the dead-reckoned pose.
	logic [ddo_pkg::DIST_W-1:0]     reg_dist;
	logic [ddo_pkg::ANG_W-1:0]      reg_turn;
	logic [ddo_pkg::POS_OUT_W-1:0]  reg_x;
	logic [ddo_pkg::POS_OUT_W-1:0]  reg_y;
	logic [ddo_pkg::HEAD_OUT_W-1:0] reg_head;
	logic [ddo_pkg::POS_W-1:0]      odo_x;
	logic [ddo_pkg::POS_W-1:0]      odo_y;
	logic [ddo_pkg::ANG_W-1:0]      odo_head;

	pose_t pose_due[$];   // predicted poses, oldest first
	job_t  jobs[$];       // planned transactions and pauses

	int ticks_sent  = 0;
	int writes_done = 0;
	int pauses_done = 0;
	int poses_seen  = 0;
	int mismatches  = 0;

	// Shared between the driver and the receiver side.
	int unsigned sink_stall_pct = 0;
	logic        sink_calm      = 1'b0;

	// Filled by the stimulus plan.
	int unsigned plan_gap_pct   = 0;
	int unsigned plan_stall_pct = 0;
	logic        plan_calm      = 1'b0;
	int          ticks_planned  = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	function automatic void reload_pose();
		odo_x    = {reg_x, 16'b0};
		odo_y    = {reg_y, 16'b0};
		odo_head = {reg_head, 16'b0};
	endfunction

	function automatic void store_register(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
			input logic [ddo_pkg::DIST_W-1:0] val);
		case (idx)
			ddo_pkg::CFG_DIST: reg_dist = val;
			ddo_pkg::CFG_TURN: reg_turn = val;
			ddo_pkg::CFG_X: begin
				reg_x = val;
				reload_pose();
			end
			ddo_pkg::CFG_Y: begin
				reg_y = val;
				reload_pose();
			end
			ddo_pkg::CFG_HEAD: begin
				reg_head = val[ddo_pkg::HEAD_OUT_W-1:0];
				reload_pose();
			end
			default: ;  // undecoded index: no effect
		endcase
	endfunction

	// Cosine and sine (Q2.30) of a binary angle: fold to the nearest quarter
	// turn, rotate the residual, then apply the quadrant by sign and swap.
	function automatic void rotate_unit(input logic [31:0] angle,
			output longint co, output longint si);
		logic [31:0] quad;
		logic [31:0] resid;
		longint x, y, z, t, step_ang;
		int i;
		quad  = ((angle + ddo_pkg::OCTANT) >> 30) & 32'd3;
		resid = angle - (quad << 30);
		z = $signed(resid);
		x = ROT_GAIN;
		y = 0;
		for (i = 0; i < ROT_STEPS; i++) begin
			step_ang = ATAN_REV[(ATAN_N - 1 - i)*32 +: 32];
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - step_ang;
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + step_ang;
			end
			x = t;
		end
		case (quad[1:0])
			2'd0: begin co = x;  si = y;  end
			2'd1: begin co = -y; si = x;  end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endfunction

	// per_tick * sum * trig / 2^31, truncated toward zero, kept to the pose width.
	function automatic logic [ddo_pkg::POS_W-1:0] travel_part(input logic [31:0] per_tick,
			input longint sum, input longint trig);
		logic [63:0]  us, ut;
		logic [127:0] mag;
		logic         neg;
		neg = (sum < 0) != (trig < 0);
		us  = (sum < 0) ? -sum : sum;
		ut  = (trig < 0) ? -trig : trig;
		mag = {96'b0, per_tick} * {64'b0, us} * {64'b0, ut};
		mag = mag >> 31;
		if (neg)
			mag = -mag;
		return mag[ddo_pkg::POS_W-1:0];
	endfunction

	// Advance the pose by one tick pair and return the pose the core must emit.
	function automatic pose_t advance_pose(input logic signed [TICK_W-1:0] lt,
			input logic signed [TICK_W-1:0] rt);
		longint             l, r, sum, diff, co, si;
		logic signed [63:0] turn_prod;
		logic [31:0]        mid;
		pose_t              p;
		l = lt;
		r = rt;
		sum  = l + r;
		diff = r - l;
		turn_prod = $signed({32'b0, reg_turn}) * diff;
		// midpoint heading: floor half of the wrapped turn
		mid = odo_head + turn_prod[32:1];
		rotate_unit(mid, co, si);
		odo_x    = odo_x + travel_part(reg_dist, sum, co);
		odo_y    = odo_y + travel_part(reg_dist, sum, si);
		odo_head = odo_head + turn_prod[31:0];
		p.x       = odo_x[47:16];
		p.y       = odo_y[47:16];
		p.heading = odo_head[31:16];
		return p;
	endfunction

	function automatic void add_ticks(input int l, input int r);
		job_t j;
		j.kind        = JOB_TICKS;
		j.left_ticks  = l[TICK_W-1:0];
		j.right_ticks = r[TICK_W-1:0];
		j.index       = '0;
		j.data        = '0;
		j.hold        = ($urandom_range(99, 0) < plan_gap_pct) ? $urandom_range(16, 1) : 0;
		j.stall_pct   = plan_stall_pct;
		j.calm        = plan_calm;
		jobs.push_back(j);
		ticks_planned++;
	endfunction

	function automatic void add_write(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
			input logic [ddo_pkg::DIST_W-1:0] val);
		job_t j;
		j.kind        = JOB_WRITE;
		j.left_ticks  = '0;
		j.right_ticks = '0;
		j.index       = idx;
		j.data        = val;
		j.hold        = 0;
		j.stall_pct   = plan_stall_pct;
		j.calm        = plan_calm;
		jobs.push_back(j);
	endfunction

	function automatic void add_pause();
		job_t j;
		j.kind        = JOB_PAUSE;
		j.left_ticks  = '0;
		j.right_ticks = '0;
		j.index       = '0;
		j.data        = '0;
		j.hold        = 0;
		j.stall_pct   = plan_stall_pct;
		j.calm        = plan_calm;
		jobs.push_back(j);
	endfunction

	// Driver: retire accepted transactions into the predictor, then present the
	// next planned job. A register write or a pause waits until no pose is due.
	job_t        head_job;
	int unsigned wait_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_vld <= 1'b0;
			wr_vld   <= 1'b0;
			wait_cnt = 0;
			// predictor follows the core's register reset values
			reg_dist = ddo_pkg::DIST_RST;
			reg_turn = ddo_pkg::TURN_RST;
			reg_x    = ddo_pkg::X_RST;
			reg_y    = ddo_pkg::Y_RST;
			reg_head = ddo_pkg::HEAD_RST;
			reload_pose();
		end else begin : drive
			logic next_tick;
			logic next_wr;
			logic settled;
			next_tick = 1'b0;
			next_wr   = 1'b0;
			if (tick_vld && ticks_ch.ready) begin
				pose_due.push_back(advance_pose(tick_l, tick_r));
				ticks_sent++;
			end
			if (wr_vld && cfg_ch.ready) begin
				store_register(wr_idx, wr_data);
				writes_done++;
			end
			settled = (pose_due.size() == 0);
			if (tick_vld && !ticks_ch.ready) begin
				// hold the tick transaction until it is taken
			end else if (wr_vld && !cfg_ch.ready) begin
				// hold the register write until it is taken
			end else begin
				if (jobs.size() != 0) begin
					head_job = jobs[0];
					if (wait_cnt < head_job.hold) begin
						wait_cnt++;
					end else begin
						case (head_job.kind)
							JOB_TICKS: begin
								void'(jobs.pop_front());
								wait_cnt       = 0;
								next_tick      = 1'b1;
								tick_l         <= head_job.left_ticks;
								tick_r         <= head_job.right_ticks;
								sink_stall_pct = head_job.stall_pct;
								sink_calm      = head_job.calm;
							end
							JOB_WRITE: begin
								if (settled) begin
									void'(jobs.pop_front());
									next_wr = 1'b1;
									wr_idx  <= head_job.index;
									wr_data <= head_job.data;
								end
							end
							default: begin
								if (settled) begin
									void'(jobs.pop_front());
									pauses_done++;
								end
							end
						endcase
					end
				end
				tick_vld <= next_tick;
				wr_vld   <= next_wr;
			end
		end
	end

	// Monitor: check each taken pose against the oldest prediction, and stall
	// the pose channel in random bursts unless the run is in its calm stretch.
	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_rdy <= 1'b0;
			stall_left = 0;
		end else begin : watch
			pose_t want;
			if (pose_ch.valid && pose_rdy) begin
				poses_seen++;
				if (pose_due.size() == 0) begin
					report_mismatch($sformatf("pose with none due: x=%h y=%h heading=%h",
						pose_ch.x_out, pose_ch.y_out, pose_ch.heading_out));
				end else begin
					want = pose_due.pop_front();
					if (pose_ch.x_out !== want.x)
						report_mismatch($sformatf("pose %0d x_out got %h want %h",
							poses_seen, pose_ch.x_out, want.x));
					if (pose_ch.y_out !== want.y)
						report_mismatch($sformatf("pose %0d y_out got %h want %h",
							poses_seen, pose_ch.y_out, want.y));
					if (pose_ch.heading_out !== want.heading)
						report_mismatch($sformatf("pose %0d heading_out got %h want %h",
							poses_seen, pose_ch.heading_out, want.heading));
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				pose_rdy <= 1'b0;
			end else if (!sink_calm && $urandom_range(99, 0) < sink_stall_pct) begin
				// begin a stall burst
				stall_left = $urandom_range(15, 0);
				pose_rdy <= 1'b0;
			end else begin
				pose_rdy <= 1'b1;
			end
		end
	end

	// Stimulus plan, end of run and verdict.
	initial begin : plan
		int n_items;
		int n_writes;
		int l, r, mag;
		logic [ddo_pkg::CFG_IDX_W-1:0] idx;
		logic [ddo_pkg::DIST_W-1:0]    val;
		logic [ddo_pkg::HEAD_OUT_W-1:0] corner_head[5];

		corner_head = '{16'h0000, 16'h6000, 16'hA000, 16'hE000, 16'hFFFF};

		// Directed part. Start on the reset registers and reset pose.
		plan_gap_pct   = 0;
		plan_stall_pct = 30;
		add_ticks(0, 0);
		add_ticks(100, 100);
		add_ticks(TICK_MAX, TICK_MAX);
		add_ticks(TICK_MIN, TICK_MIN);

		// Largest scale factors, hardest turns; a scale write leaves the pose alone.
		add_write(ddo_pkg::CFG_DIST, '1);
		add_write(ddo_pkg::CFG_TURN, '1);
		add_ticks(TICK_MIN, TICK_MAX);
		add_ticks(TICK_MAX, TICK_MIN);
		add_ticks(1, 0);
		add_ticks(0, -1);

		// Undecoded index is ignored; then push the pose across the wrap.
		add_write(CFG_SPARE, 32'hDEAD_BEEF);
		add_write(ddo_pkg::CFG_X, 32'h7FFF_FFFF);
		add_write(ddo_pkg::CFG_Y, 32'h8000_0000);
		add_write(ddo_pkg::CFG_HEAD, 32'hFFFF_2000);
		add_ticks(TICK_MAX, TICK_MAX);
		add_ticks(TICK_MAX, TICK_MAX);
		add_ticks(TICK_MIN, TICK_MIN);

		// Zero scale factors: no motion whatever the ticks.
		add_write(ddo_pkg::CFG_DIST, '0);
		add_write(ddo_pkg::CFG_TURN, '0);
		add_ticks(TICK_MAX, TICK_MIN);
		add_write(ddo_pkg::CFG_DIST, 32'd1);
		add_ticks(1, 1);

		// Headings on and next to the quadrant boundaries.
		add_write(ddo_pkg::CFG_DIST, ddo_pkg::DIST_RST);
		add_write(ddo_pkg::CFG_TURN, ddo_pkg::TURN_RST);
		foreach (corner_head[k]) begin
			add_write(ddo_pkg::CFG_HEAD, {16'h0000, corner_head[k]});
			add_ticks(7, 7);
		end

		// Random phases: settle, rewrite a few registers, then a run of ticks.
		while (ticks_planned < TOTAL_ITEMS) begin
			plan_calm = (ticks_planned >= TOTAL_ITEMS - CALM_ITEMS);
			if (plan_calm) begin
				plan_gap_pct   = 0;
				plan_stall_pct = 0;
			end else begin
				case ($urandom_range(3, 0))
					0: plan_gap_pct = 0;
					1: plan_gap_pct = 5;
					2: plan_gap_pct = 20;
					default: plan_gap_pct = 50;
				endcase
				case ($urandom_range(3, 0))
					0: plan_stall_pct = 0;
					1: plan_stall_pct = 5;
					2: plan_stall_pct = 20;
					default: plan_stall_pct = 50;
				endcase
			end
			add_pause();
			n_writes = $urandom_range(3, 0);
			repeat (n_writes) begin
				if ($urandom_range(7, 0) == 0)
					idx = ddo_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_LAST, int'(CFG_SPARE)));
				else
					idx = ddo_pkg::CFG_IDX_W'($urandom_range(int'(ddo_pkg::CFG_HEAD),
						int'(ddo_pkg::CFG_DIST)));
				case ($urandom_range(9, 0))
					0: val = '0;
					1: val = '1;
					2: val = 32'h8000_0000;
					3: val = 32'h7FFF_FFFF;
					4, 5: val = $urandom();
					default: val = $urandom_range(32'h00FF_FFFF, 0);
				endcase
				add_write(idx, val);
			end
			n_items = plan_calm ? CALM_ITEMS : $urandom_range(70, 15);
			repeat (n_items) begin
				mag = $urandom_range(400, 1);
				case ($urandom_range(9, 0))
					0, 1: begin  // anything the fields allow
						l = $signed(16'($urandom()));
						r = $signed(16'($urandom()));
					end
					2: begin     // straight line
						l = $urandom_range(2 * mag, 0) - mag;
						r = l;
					end
					3: begin     // spin in place
						l = $urandom_range(2 * mag, 0) - mag;
						r = -l;
					end
					4: begin     // field extremes
						l = $urandom_range(1, 0) ? TICK_MAX : TICK_MIN;
						r = $urandom_range(1, 0) ? TICK_MAX : TICK_MIN;
					end
					default: begin  // gentle driving
						l = $urandom_range(2 * mag, 0) - mag;
						r = l + $urandom_range(40, 0) - 20;
					end
				endcase
				add_ticks(l, r);
				if (!plan_calm && $urandom_range(39, 0) == 0)
					add_pause();
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every job taken, every pose back, then let any stray pose show.
		while (jobs.size() != 0 || tick_vld || wr_vld)
			@(posedge clk);
		while (pose_due.size() != 0)
			@(posedge clk);
		repeat (3 * LATENCY) @(posedge clk);

		$display("Covered %0d tick transactions, %0d register writes, %0d sender pauses.",
			ticks_sent, writes_done, pauses_done);
		$display("Checked %0d poses, %0d mismatches.", poses_seen, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: %0d jobs left, %0d poses due.", jobs.size(), pose_due.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_if.sv
rtl/ddo_serial_mul.sv
rtl/ddo_cordic.sv
rtl/differential_drive_odometry_core.sv
test/tb_differential_drive_odometry_core.sv
